### hdl/slmc_pkg.sv
`timescale 1ns / 1ps

package slmc_pkg;

  typedef logic [24:0] page_t;
  typedef logic [31:0] age_t;
  typedef logic [14:0] map_page_t;
  typedef logic [15:0] cfg_word_t;

  localparam age_t AGE_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] OC_REAL_HIT       = 2'd0;
  localparam logic [1:0] OC_GHOST_KEPT     = 2'd1;
  localparam logic [1:0] OC_GHOST_PROMOTED = 2'd2;
  localparam logic [1:0] OC_MISS           = 2'd3;

  typedef struct packed {
    logic  valid;
    logic  dirty;
    age_t  age;
    page_t page;
  } slot_t;

  typedef struct packed {
    logic [25:0] first_sector;
    logic [7:0]  sector_count;
    logic        is_read;
  } in_item_t;

  typedef struct packed {
    page_t     page_number;
    logic [1:0] outcome;
    map_page_t map_read_page;
    logic      demoted_valid;
    page_t     demoted_page;
    logic      evicted_valid;
    logic      writeback_needed;
    map_page_t writeback_map_page;
    logic      last;
  } out_item_t;

  function automatic age_t age_inc(input age_t a);
    age_inc = (a == AGE_MAX) ? a : a + 32'd1;
  endfunction

  function automatic page_t page_diff(input page_t page, input cfg_word_t off);
    page_diff = (page >= {9'd0, off}) ? page - {9'd0, off} : '0;
  endfunction

endpackage

### hdl/slmc_stream_if.sv
`timescale 1ns / 1ps

interface slmc_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/segmented_lru_mapping_cache.sv
// Segmented LRU mapping cache for a page-mapped flash translation layer.
// The in_ch channel takes one host request (first sector, sector count, read
// flag) per transfer; the request is split into 4-sector pages that are offset
// by the map_page_count register, written through cfg_write_en and cfg_wdata.
// The out_ch channel gives one transfer per page, in page order, with last set
// on the final page. A request with zero sectors gives no transfer.
// Each page scans both cache memories one entry per cycle through their single
// read port. The next request is taken in the cycle after the last page's result
// enters the output register. After reset a clearing pass empties both
// memories; no request is taken during it.
// A finished result waits in the output register while the following page is
// scanned; if the receiver still stalls when that page is done, the block
// holds until the register is free.
`timescale 1ns / 1ps

module segmented_lru_mapping_cache #(
  parameter int REAL_ENTRIES          = 256,
  parameter int GHOST_ENTRIES         = 64,
  parameter int ENTRIES_PER_MAP_PAGE  = 512,
  parameter int MAX_PAGES_PER_REQUEST = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  slmc_pkg::cfg_word_t cfg_wdata,
  slmc_stream_if.sink        in_ch,
  slmc_stream_if.source      out_ch
);
  import slmc_pkg::*;

  localparam int SCAN_LEN = (REAL_ENTRIES > GHOST_ENTRIES) ? REAL_ENTRIES : GHOST_ENTRIES;
  localparam int CW   = $clog2(SCAN_LEN);
  localparam int RIW  = $clog2(REAL_ENTRIES);
  localparam int GIW  = (GHOST_ENTRIES > 1) ? $clog2(GHOST_ENTRIES) : 1;
  localparam int RCW  = $clog2(REAL_ENTRIES + 1);
  localparam int GCW  = $clog2(GHOST_ENTRIES + 1);
  localparam int SH   = 25 + $clog2(ENTRIES_PER_MAP_PAGE);
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SH) + 64'(ENTRIES_PER_MAP_PAGE) - 64'd1) / 64'(ENTRIES_PER_MAP_PAGE);
  localparam logic [25:0] RECIP = RECIP64[25:0];

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_DIFF  = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_UPD   = 7'b1000000
  } state_t;

  slot_t real_mem [REAL_ENTRIES];
  slot_t ghost_mem [GHOST_ENTRIES];

  state_t         state_r, state_nxt;
  logic [CW-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic           rd_v_r, gd_v_r;
  logic [CW-1:0]  idx_d_r;
  slot_t          real_q_r, ghost_q_r;
  page_t          blk_r;
  logic [6:0]     pages_left_r;
  logic           is_read_r;
  cfg_word_t      map_page_count_r;

  logic           r_hit_r, r_free_r, r_old_r;
  logic [RIW-1:0] r_hit_idx_r, r_free_idx_r, r_old_idx_r;
  slot_t          r_hit_e_r, r_old_e_r;
  logic           g_hit_r, g_free_r, g_old_r;
  logic [GIW-1:0] g_hit_idx_r, g_free_idx_r, g_old_idx_r;
  slot_t          g_hit_e_r, g_old_e_r;

  page_t          blk_d_r, ev_d_r;
  logic [50:0]    prod_blk_r, prod_ev_r;
  logic [50:0]    q_blk, q_ev;

  logic [RCW-1:0] real_count_r, real_count_nxt;
  logic [GCW-1:0] ghost_count_r, ghost_count_nxt;
  page_t          newest_page_r, newest_page_nxt;
  age_t           newest_age_r, newest_age_nxt;

  logic           out_valid_r;
  out_item_t      out_data_r, upd_item;

  logic           rm_we, gm_we;
  logic [RIW-1:0] rm_wa;
  logic [GIW-1:0] gm_wa;
  slot_t          rm_wd, gm_wd;

  logic           in_fire, upd_fire, start_scan;
  logic [26:0]    end_sector;
  page_t          page_span;
  logic [6:0]     req_pages;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign upd_fire     = (state_r == ST_UPD) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign end_sector = {1'b0, in_ch.data.first_sector} + 27'(in_ch.data.sector_count) - 27'd1;
  assign page_span  = end_sector[26:2] - {1'b0, in_ch.data.first_sector[25:2]} + 25'd1;
  assign req_pages  = (page_span > 25'(MAX_PAGES_PER_REQUEST)) ?
                      7'(MAX_PAGES_PER_REQUEST) : page_span[6:0];

  assign start_scan = (state_nxt == ST_SCAN) && (state_r != ST_SCAN);
  assign q_blk = prod_blk_r >> SH;
  assign q_ev  = prod_ev_r >> SH;

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        scan_cnt_nxt = scan_cnt_r + CW'(1);
        if (scan_cnt_r == CW'(SCAN_LEN - 1)) begin
          scan_cnt_nxt = '0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && in_ch.data.sector_count != 8'd0) begin
          scan_cnt_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + CW'(1);
        if (scan_cnt_r == CW'(SCAN_LEN - 1)) begin
          scan_cnt_nxt = '0;
          state_nxt    = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_UPD;
      ST_UPD: begin
        if (upd_fire) begin
          state_nxt = (pages_left_r == 7'd1) ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    slot_t e;
    age_t  na;
    page_t np;
    rm_we = 1'b0;
    gm_we = 1'b0;
    rm_wa = scan_cnt_r[RIW-1:0];
    gm_wa = scan_cnt_r[GIW-1:0];
    rm_wd = '0;
    gm_wd = '0;
    real_count_nxt  = real_count_r;
    ghost_count_nxt = ghost_count_r;
    np = newest_page_r;
    na = newest_age_r;
    e  = '0;
    upd_item = '0;
    upd_item.page_number = blk_r;
    upd_item.last        = (pages_left_r == 7'd1);

    if (state_r == ST_CLEAR) begin
      rm_we = (int'(scan_cnt_r) < REAL_ENTRIES);
      gm_we = (int'(scan_cnt_r) < GHOST_ENTRIES);
    end else if (upd_fire) begin
      if (r_hit_r) begin
        e       = r_hit_e_r;
        e.age   = age_inc(e.age);
        e.dirty = e.dirty | !is_read_r;
        if (e.page == newest_page_r) na = e.age;
        if (na <= e.age) begin
          np = blk_r;
          na = e.age;
        end
        rm_we = 1'b1;
        rm_wa = r_hit_idx_r;
        rm_wd = e;
        upd_item.outcome = OC_REAL_HIT;
      end else if (g_hit_r) begin
        e       = g_hit_e_r;
        e.age   = age_inc(e.age);
        e.dirty = e.dirty | !is_read_r;
        if (e.page == newest_page_r) na = e.age;
        gm_we = 1'b1;
        gm_wa = g_hit_idx_r;
        if (r_old_r && r_old_e_r.age <= e.age) begin
          rm_we = 1'b1;
          rm_wa = r_old_idx_r;
          rm_wd = e;
          gm_wd = r_old_e_r;
          upd_item.demoted_valid = 1'b1;
          upd_item.demoted_page  = r_old_e_r.page;
          upd_item.outcome       = OC_GHOST_PROMOTED;
        end else begin
          gm_wd = e;
          upd_item.outcome = OC_GHOST_KEPT;
        end
      end else begin
        upd_item.outcome       = OC_MISS;
        upd_item.map_read_page = q_blk[14:0];
        rm_we = 1'b1;
        rm_wd = '{valid: 1'b1, dirty: !is_read_r, age: age_inc(newest_age_r), page: blk_r};
        np = blk_r;
        na = age_inc(newest_age_r);
        if (real_count_r == RCW'(REAL_ENTRIES)) begin
          rm_wa = r_old_idx_r;
          gm_we = 1'b1;
          gm_wd = r_old_e_r;
          upd_item.demoted_valid = 1'b1;
          upd_item.demoted_page  = r_old_e_r.page;
          if (ghost_count_r == GCW'(GHOST_ENTRIES)) begin
            gm_wa = g_old_idx_r;
            upd_item.evicted_valid = 1'b1;
            if (g_old_e_r.dirty) begin
              upd_item.writeback_needed   = 1'b1;
              upd_item.writeback_map_page = q_ev[14:0];
            end
          end else begin
            gm_wa = g_free_idx_r;
            ghost_count_nxt = ghost_count_r + GCW'(1);
          end
        end else begin
          rm_wa = r_free_idx_r;
          real_count_nxt = real_count_r + RCW'(1);
        end
      end
    end
    newest_page_nxt = np;
    newest_age_nxt  = na;
  end

  always_ff @(posedge clk) begin
    if (rm_we) real_mem[rm_wa] <= rm_wd;
    real_q_r <= real_mem[scan_cnt_r[RIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (gm_we) ghost_mem[gm_wa] <= gm_wd;
    ghost_q_r <= ghost_mem[scan_cnt_r[GIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      scan_cnt_r       <= '0;
      rd_v_r           <= 1'b0;
      gd_v_r           <= 1'b0;
      map_page_count_r <= '0;
      real_count_r     <= '0;
      ghost_count_r    <= '0;
      newest_page_r    <= '0;
      newest_age_r     <= '0;
      out_valid_r      <= 1'b0;
      pages_left_r     <= '0;
      r_hit_r  <= 1'b0;
      r_free_r <= 1'b0;
      r_old_r  <= 1'b0;
      g_hit_r  <= 1'b0;
      g_free_r <= 1'b0;
      g_old_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      scan_cnt_r    <= scan_cnt_nxt;
      rd_v_r        <= (state_r == ST_SCAN) && (int'(scan_cnt_r) < REAL_ENTRIES);
      gd_v_r        <= (state_r == ST_SCAN) && (int'(scan_cnt_r) < GHOST_ENTRIES);
      real_count_r  <= real_count_nxt;
      ghost_count_r <= ghost_count_nxt;
      newest_page_r <= newest_page_nxt;
      newest_age_r  <= newest_age_nxt;
      if (cfg_write_en) map_page_count_r <= cfg_wdata;

      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_fire) begin
        pages_left_r <= req_pages;
      end else if (upd_fire) begin
        pages_left_r <= pages_left_r - 7'd1;
      end

      if (start_scan) begin
        r_hit_r  <= 1'b0;
        r_free_r <= 1'b0;
        r_old_r  <= 1'b0;
        g_hit_r  <= 1'b0;
        g_free_r <= 1'b0;
        g_old_r  <= 1'b0;
      end else begin
        if (rd_v_r) begin
          if (real_q_r.valid) begin
            if (real_q_r.page == blk_r) r_hit_r <= 1'b1;
            if (!r_old_r || real_q_r.age <= r_old_e_r.age) r_old_r <= 1'b1;
          end else if (!r_free_r) begin
            r_free_r <= 1'b1;
          end
        end
        if (gd_v_r) begin
          if (ghost_q_r.valid) begin
            if (ghost_q_r.page == blk_r) g_hit_r <= 1'b1;
            if (!g_old_r || ghost_q_r.age <= g_old_e_r.age) g_old_r <= 1'b1;
          end else if (!g_free_r) begin
            g_free_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= scan_cnt_r;
    if (in_fire) begin
      blk_r     <= {1'b0, in_ch.data.first_sector[25:2]} + {9'd0, map_page_count_r};
      is_read_r <= in_ch.data.is_read;
    end else if (upd_fire) begin
      blk_r <= blk_r + 25'd1;
    end
    if (upd_fire) out_data_r <= upd_item;

    if (rd_v_r) begin
      if (real_q_r.valid) begin
        if (real_q_r.page == blk_r) begin
          r_hit_idx_r <= idx_d_r[RIW-1:0];
          r_hit_e_r   <= real_q_r;
        end
        if (!r_old_r || real_q_r.age <= r_old_e_r.age) begin
          r_old_idx_r <= idx_d_r[RIW-1:0];
          r_old_e_r   <= real_q_r;
        end
      end else if (!r_free_r) begin
        r_free_idx_r <= idx_d_r[RIW-1:0];
      end
    end
    if (gd_v_r) begin
      if (ghost_q_r.valid) begin
        if (ghost_q_r.page == blk_r) begin
          g_hit_idx_r <= idx_d_r[GIW-1:0];
          g_hit_e_r   <= ghost_q_r;
        end
        if (!g_old_r || ghost_q_r.age <= g_old_e_r.age) begin
          g_old_idx_r <= idx_d_r[GIW-1:0];
          g_old_e_r   <= ghost_q_r;
        end
      end else if (!g_free_r) begin
        g_free_idx_r <= idx_d_r[GIW-1:0];
      end
    end

    if (state_r == ST_DIFF) begin
      blk_d_r <= page_diff(blk_r, map_page_count_r);
      ev_d_r  <= page_diff(g_old_e_r.page, map_page_count_r);
    end
    if (state_r == ST_MUL) begin
      prod_blk_r <= 51'(blk_d_r) * 51'(RECIP);
      prod_ev_r  <= 51'(ev_d_r) * 51'(RECIP);
    end
  end

`ifndef NO_ASSERTIONS
  a_real_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    real_count_r <= RCW'(REAL_ENTRIES))
    else $error("real segment count exceeds its size");

  a_ghost_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ghost_count_r <= GCW'(GHOST_ENTRIES))
    else $error("ghost segment count exceeds its size");

  a_writeback_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.writeback_needed |-> out_data_r.evicted_valid)
    else $error("write-back reported without an eviction");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.evicted_valid |-> out_data_r.outcome == OC_MISS)
    else $error("eviction reported on a hit");

  a_upd_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire |=> state_r == ST_IDLE || state_r == ST_SCAN)
    else $error("page update did not return to idle or scan");
`endif

endmodule
